/* rtl/core/iwi_pkg.sv */
// Package for the IMU window interpolator: constants, types, sequencer states.
// No dependencies.
package iwi_pkg;
  localparam int RING_DEPTH = 32;
  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int INNER_CAP = 30;
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam logic [47:0] T48_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        mode;
    logic [47:0] t0;
    logic [47:0] t1;
    logic [47:0] accel;
    logic [47:0] rate;
  } iwi_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SCAN_WAIT, ST_CHECK, ST_RD_P, ST_RD_Q, ST_DIV, ST_MUL, ST_EMIT,
    ST_INNER_RD, ST_INNER_EMIT, ST_BAD
  } iwi_state_t;

  function automatic logic [47:0] clamp_time(input logic [47:0] cam, input logic [31:0] off);
    logic signed [49:0] s;
    s = $signed({2'b00, cam}) + 50'($signed(off));
    if (s < 0) return '0;
    if (s > $signed({2'b00, T48_MAX})) return T48_MAX;
    return s[47:0];
  endfunction
endpackage

/* rtl/core/iwi_if.sv */
// Valid/ready channel interface carrying one beat.
// Depends on nothing.
interface iwi_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/iwi_front.sv */
// Front end: takes input beats, clamps query times, queues commands (2 deep).
// Depends on iwi_pkg.
module iwi_front import iwi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [47:0] in_sample_time,
  input  logic [47:0] in_accel,
  input  logic [47:0] in_rate,
  input  logic [47:0] in_window_start,
  input  logic [47:0] in_window_end,
  input  logic [31:0] cfg_offset,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output iwi_cmd_t    cmd
);
  iwi_cmd_t q_r [2];
  logic     rd_r, wr_r;
  logic [1:0] cnt_r;
  iwi_cmd_t c;
  logic push, pop;

  always_comb begin
    c.mode = in_mode;
    c.accel = in_accel;
    c.rate = in_rate;
    if (in_mode == MODE_QUERY) begin
      c.t0 = clamp_time(in_window_start, cfg_offset);
      c.t1 = clamp_time(in_window_end, cfg_offset);
    end else begin
      c.t0 = in_sample_time;
      c.t1 = '0;
    end
  end

  assign in_ready = cnt_r != 2'd2;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd = q_r[rd_r];
  assign push = in_valid && in_ready;
  assign pop = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= c;
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* rtl/core/iwi_div.sv */
// Restoring divider: 17-bit quotient of (num << 16) / den, one bit per cycle.
// Depends on iwi_pkg.
module iwi_div import iwi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [47:0] den,
  output logic        done,
  output logic [16:0] quo
);
  logic [48:0] rem_r;
  logic [47:0] den_r;
  logic [16:0] q_r;
  logic [4:0]  n_r;
  logic        busy_r;
  logic [49:0] tr;
  logic [49:0] sub;
  logic [16:0] dividend_r;

  assign tr = {rem_r, dividend_r[16]};
  assign sub = tr - {2'b00, den_r};
  assign quo = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        n_r <= 5'd0;
        // num <= den, so num >> 1 is already below den
        rem_r <= {2'b00, num[47:1]};
        den_r <= den;
        q_r <= '0;
        dividend_r <= {num[0], 16'h0};
      end else if (busy_r) begin
        dividend_r <= {dividend_r[15:0], 1'b0};
        if (!sub[49]) begin
          rem_r <= sub[48:0];
        end else begin
          rem_r <= tr[48:0];
        end
        q_r <= {q_r[15:0], !sub[49]};
        if (n_r == 5'd16) busy_r <= 1'b0;
        if (n_r == 5'd16) done <= 1'b1;
        n_r <= n_r + 5'd1;
      end
    end
  end
endmodule

/* rtl/core/iwi_back.sv */
// Back end: sample ring memory, window search, interpolation, result beats.
// Depends on iwi_pkg and iwi_div.
module iwi_back import iwi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  iwi_cmd_t    cmd,
  output logic        out_valid_o,
  input  logic        out_ready,
  output logic [47:0] o_time,
  output logic [47:0] o_accel,
  output logic [47:0] o_rate,
  output logic        o_ok,
  output logic        o_last
);
  logic [143:0] mem [RING_DEPTH];
  logic [143:0] rd_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [47:0] newest_r, newest_nxt;
  logic        we;
  logic [IDX_W-1:0] wa;

  iwi_state_t st_r, st_nxt;
  iwi_cmd_t   c_r, c_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, is_r, is_nxt, ie_r, ie_nxt;
  logic       fs_r, fs_nxt, fe_r, fe_nxt, phase_r, phase_nxt;
  logic [4:0] inner_r, inner_nxt;
  logic [143:0] p_r, p_nxt;
  logic [47:0] tt;
  logic        dstart, ddone;
  logic [16:0] quo;
  logic [16:0] al_r, al_nxt;
  logic signed [33:0] acc_r [6];
  logic signed [33:0] acc_nxt [6];
  logic [2:0]  lane_r, lane_nxt;
  logic        ov_r, ov_nxt;
  logic [47:0] ot_r, ot_nxt, oa_r, oa_nxt, orr_r, orr_nxt;
  logic        ook_r, ook_nxt, ol_r, ol_nxt;

  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] o, input logic [CNT_W-1:0] l);
    logic [CNT_W:0] s;
    s = {1'b0, o} + {1'b0, l};
    if (s >= (CNT_W+1)'(RING_DEPTH)) s = s - (CNT_W+1)'(RING_DEPTH);
    return s[IDX_W-1:0];
  endfunction

  function automatic logic signed [33:0] prod(input logic [15:0] a, input logic [16:0] w);
    return 34'($signed(a) * $signed({1'b0, w}));
  endfunction

  assign o_time = ot_r;
  assign o_accel = oa_r;
  assign o_rate = orr_r;
  assign o_ok = ook_r;
  assign o_last = ol_r;
  assign out_valid_o = ov_r;
  assign tt = phase_r ? c_r.t1 : c_r.t0;

  iwi_div u_div (.clk, .rst_n, .start(dstart), .num(tt - p_r[47:0]),
    .den(rd_r[47:0] - p_r[47:0]), .done(ddone), .quo(quo));

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= {cmd.rate, cmd.accel, cmd.t0};
    rd_r <= mem[rd_addr];
  end

  always_comb begin
    st_nxt = st_r; c_nxt = c_r; i_nxt = i_r; is_nxt = is_r; ie_nxt = ie_r;
    fs_nxt = fs_r; fe_nxt = fe_r; phase_nxt = phase_r; inner_nxt = inner_r;
    p_nxt = p_r; al_nxt = al_r; acc_nxt = acc_r; lane_nxt = lane_r;
    ov_nxt = ov_r; ot_nxt = ot_r; oa_nxt = oa_r; orr_nxt = orr_r;
    ook_nxt = ook_r; ol_nxt = ol_r;
    oldest_nxt = oldest_r; fill_nxt = fill_r; newest_nxt = newest_r;
    we = 1'b0; wa = slot(oldest_r, fill_r); rd_addr = slot(oldest_r, i_r);
    dstart = 1'b0; cmd_ready = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          c_nxt = cmd;
          if (cmd.mode == MODE_PUSH) begin
            if (fill_r == '0 || cmd.t0 >= newest_r) begin
              we = 1'b1;
              newest_nxt = cmd.t0;
              if (fill_r < CNT_W'(RING_DEPTH)) begin
                fill_nxt = fill_r + 1'b1;
              end else begin
                wa = oldest_r;
                oldest_nxt = (oldest_r == IDX_W'(RING_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
              end
            end
          end else begin
            i_nxt = '0; fs_nxt = 1'b0; fe_nxt = 1'b0;
            is_nxt = fill_r; ie_nxt = fill_r;
            st_nxt = (fill_r == '0 || cmd.t1 < cmd.t0) ? ST_BAD : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        st_nxt = ST_SCAN_WAIT;
      end
      ST_SCAN_WAIT: begin
        if (!fs_r && rd_r[47:0] >= c_r.t0) begin fs_nxt = 1'b1; is_nxt = i_r; end
        if (!fe_r && rd_r[47:0] >= c_r.t1) begin fe_nxt = 1'b1; ie_nxt = i_r; end
        if (i_r + 1'b1 == fill_r) st_nxt = ST_CHECK;
        else begin i_nxt = i_r + 1'b1; st_nxt = ST_SCAN; end
      end
      ST_CHECK: begin
        if (is_r == '0 || ie_r == '0 || is_r >= fill_r || ie_r >= fill_r) st_nxt = ST_BAD;
        else begin
          phase_nxt = 1'b0; inner_nxt = '0;
          i_nxt = is_r - 1'b1; st_nxt = ST_RD_P;
        end
      end
      ST_RD_P: begin
        i_nxt = i_r + 1'b1; st_nxt = ST_RD_Q;
      end
      ST_RD_Q: begin
        p_nxt = rd_r; st_nxt = ST_DIV;
        lane_nxt = '0;
      end
      ST_DIV: begin
        if (lane_r == 3'd0) begin
          if (rd_r[47:0] <= p_r[47:0]) begin
            if (!ov_nxt) begin
              ot_nxt = p_r[47:0]; oa_nxt = p_r[95:48]; orr_nxt = p_r[143:96];
              st_nxt = ST_EMIT;
            end
          end else begin
            lane_nxt = 3'd1;
            dstart = 1'b1;
          end
        end else if (ddone) begin
          al_nxt = (quo[16] && quo[15:0] != '0) ? 17'h10000 : quo;
          lane_nxt = '0; st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (lane_r < 3'd6) begin
          acc_nxt[lane_r] = prod(p_r[48 + 16*lane_r +: 16], 17'h10000 - al_r)
                            + prod(rd_r[48 + 16*lane_r +: 16], al_r) + 34'sd32768;
          lane_nxt = lane_r + 1'b1;
        end else if (!ov_nxt) begin
          ot_nxt = tt;
          for (int k = 0; k < 3; k++) begin
            oa_nxt[16*k +: 16] = acc_r[k][31:16];
            orr_nxt[16*k +: 16] = acc_r[k+3][31:16];
          end
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1; ook_nxt = 1'b1; ol_nxt = phase_r;
          if (phase_r) st_nxt = ST_IDLE;
          else begin i_nxt = is_r; st_nxt = ST_INNER_RD; end
        end
      end
      ST_INNER_RD: begin
        if (i_r >= ie_r || inner_r == 5'(INNER_CAP)) begin
          phase_nxt = 1'b1; i_nxt = ie_r - 1'b1; st_nxt = ST_RD_P;
        end else st_nxt = ST_INNER_EMIT;
      end
      ST_INNER_EMIT: begin
        if (rd_r[47:0] > c_r.t0 && rd_r[47:0] < c_r.t1) begin
          if (!ov_nxt) begin
            ov_nxt = 1'b1; ook_nxt = 1'b1; ol_nxt = 1'b0;
            ot_nxt = rd_r[47:0]; oa_nxt = rd_r[95:48]; orr_nxt = rd_r[143:96];
            inner_nxt = inner_r + 1'b1; i_nxt = i_r + 1'b1; st_nxt = ST_INNER_RD;
          end
        end else begin
          i_nxt = i_r + 1'b1; st_nxt = ST_INNER_RD;
        end
      end
      ST_BAD: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1; ook_nxt = 1'b0; ol_nxt = 1'b1;
          ot_nxt = '0; oa_nxt = '0; orr_nxt = '0; st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt; i_r <= i_nxt; is_r <= is_nxt; ie_r <= ie_nxt;
    fs_r <= fs_nxt; fe_r <= fe_nxt; phase_r <= phase_nxt; inner_r <= inner_nxt;
    p_r <= p_nxt; al_r <= al_nxt; acc_r <= acc_nxt; lane_r <= lane_nxt;
    ot_r <= ot_nxt; oa_r <= oa_nxt; orr_r <= orr_nxt; ook_r <= ook_nxt; ol_r <= ol_nxt;
    newest_r <= newest_nxt;
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0; oldest_r <= '0; fill_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; oldest_r <= oldest_nxt; fill_r <= fill_nxt;
    end
  end
endmodule

/* rtl/core/imu_window_interpolator_core.sv */
// Channel   Dir  Beat
// in        in   mode, sample time, accel/rate xyz, window start/end
// out       out  time, accel/rate xyz, valid, last
// cfg       in   camera time offset (write only)
// Push: a ring write in the back end. Query: a ring scan, then per interpolated
// bound neighbour reads, a division and a per-lane blend; inner samples between.
// Synchronous active-low reset empties the ring; no clearing pass.
// A 2-entry command queue lets inputs land while results stall.
// Depends on iwi_pkg, iwi_if, iwi_front, iwi_div, iwi_back.
module imu_window_interpolator_core import iwi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  iwi_if.sink   in_ch,
  iwi_if.source out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  logic [31:0] off_r;
  logic cmd_valid, cmd_ready;
  iwi_cmd_t cmd;
  logic [47:0] ot, oa, orr;
  logic ook, ol;

  always_ff @(posedge clk) begin
    if (!rst_n) off_r <= '0;
    else if (cfg_we) off_r <= cfg_wdata;
  end

  iwi_front u_front (.clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_mode(in_ch.data[0]), .in_sample_time(in_ch.data[48:1]),
    .in_accel(in_ch.data[96:49]), .in_rate(in_ch.data[144:97]),
    .in_window_start(in_ch.data[192:145]), .in_window_end(in_ch.data[240:193]),
    .cfg_offset(off_r), .cmd_valid, .cmd_ready, .cmd);

  iwi_back u_back (.clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .out_valid_o(out_ch.valid), .out_ready(out_ch.ready),
    .o_time(ot), .o_accel(oa), .o_rate(orr), .o_ok(ook), .o_last(ol));

  assign out_ch.data = {ol, ook, orr, oa, ot};
endmodule

/* tb/tb_imu_window_interpolator_core.sv */
// Testbench for imu_window_interpolator_core: drives pushes and window queries
// through valid/ready channels and checks every result against a ring predictor.
// Depends on iwi_pkg, iwi_if and the core RTL.
`timescale 1ns / 1ps

module tb_imu_window_interpolator_core;
  import iwi_pkg::*;

  localparam int IN_W = 241;
  localparam int OUT_W = 146;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 400;

  typedef logic [OUT_W-1:0] result_t;

  class imu_window_scoreboard;
    logic [47:0] time_ring[RING_DEPTH];
    logic [47:0] accel_ring[RING_DEPTH];
    logic [47:0] rate_ring[RING_DEPTH];
    int oldest;
    int fill;
    logic [31:0] cam_offset;
    result_t window_results_q[$];
    int errors;

    function new();
      oldest = 0;
      fill = 0;
      cam_offset = '0;
      errors = 0;
    endfunction

    function void expect_result(result_t r);
      window_results_q = {window_results_q, r};
    endfunction

    function int slot(int logical);
      return (oldest + logical) % RING_DEPTH;
    endfunction

    function logic [47:0] newest_time();
      return time_ring[slot(fill - 1)];
    endfunction

    function logic [47:0] to_imu_time(logic [47:0] cam);
      longint s;
      s = longint'({16'h0, cam}) + longint'($signed(cam_offset));
      if (s < 0) return '0;
      if (s > longint'({16'h0, T48_MAX})) return T48_MAX;
      return s[47:0];
    endfunction

    function logic [47:0] blend(logic [47:0] p, logic [47:0] q, longint alpha);
      logic [47:0] r;
      longint a, b, s;
      for (int j = 0; j < 3; j++) begin
        a = longint'($signed(p[16*j +: 16]));
        b = longint'($signed(q[16*j +: 16]));
        s = a * (65536 - alpha) + b * alpha + 32768;
        s = s >>> 16;
        r[16*j +: 16] = s[15:0];
      end
      return r;
    endfunction

    function void expect_bound(int i, logic [47:0] t, logic last);
      int p, q;
      longint unsigned dt, alpha;
      p = slot(i - 1);
      q = slot(i);
      if (time_ring[q] <= time_ring[p]) begin
        expect_result({last, 1'b1, rate_ring[p], accel_ring[p], time_ring[p]});
        return;
      end
      dt = time_ring[q] - time_ring[p];
      alpha = ((longint'(t) - longint'(time_ring[p])) << 16) / dt;
      if (alpha > 65536) alpha = 65536;
      expect_result({last, 1'b1, blend(rate_ring[p], rate_ring[q], alpha),
                     blend(accel_ring[p], accel_ring[q], alpha), t});
    endfunction

    function int first_at_or_above(logic [47:0] t);
      for (int i = 0; i < fill; i++)
        if (time_ring[slot(i)] >= t) return i;
      return fill;
    endfunction

    function void note_beat(iwi_cmd_t c);
      logic [47:0] ts, te;
      int is, ie, w, inner;
      if (c.mode == MODE_PUSH) begin
        if (fill > 0 && c.t0 < newest_time()) return;
        if (fill < RING_DEPTH) begin
          w = slot(fill);
          fill++;
        end else begin
          w = oldest;
          oldest = (oldest + 1) % RING_DEPTH;
        end
        time_ring[w] = c.t0;
        accel_ring[w] = c.accel;
        rate_ring[w] = c.rate;
        return;
      end
      ts = to_imu_time(c.t0);
      te = to_imu_time(c.t1);
      is = first_at_or_above(ts);
      ie = first_at_or_above(te);
      if (fill == 0 || te < ts || is == 0 || ie == 0 || is >= fill || ie >= fill) begin
        expect_result({1'b1, 1'b0, 144'h0});
        return;
      end
      expect_bound(is, ts, 1'b0);
      inner = 0;
      for (int i = is; i < ie && inner < INNER_CAP; i++) begin
        w = slot(i);
        if (time_ring[w] > ts && time_ring[w] < te) begin
          expect_result({2'b01, rate_ring[w], accel_ring[w], time_ring[w]});
          inner++;
        end
      end
      expect_bound(ie, te, 1'b1);
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (window_results_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = window_results_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: time %h/%h accel %h/%h rate %h/%h valid %b/%b last %b/%b",
                   want[47:0], got[47:0], want[95:48], got[95:48], want[143:96],
                   got[143:96], want[144], got[144], want[145], got[145]);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [31:0] cfg_wdata;
  iwi_if #(.W(IN_W)) in_ch ();
  iwi_if #(.W(OUT_W)) out_ch ();

  imu_window_interpolator_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  imu_window_scoreboard sb = new();
  bit no_idle;
  bit hold_req;
  logic [47:0] next_time;
  int idle_count;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function bit idle_now();
    return !no_idle && $urandom_range(99) < 6;
  endfunction

  function logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready = !idle_now();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_beat(out_ch.data);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_beat(iwi_cmd_t c);
    logic [IN_W-1:0] beat;
    if (c.mode == MODE_PUSH) beat = {rand48(), rand48(), c.rate, c.accel, c.t0, c.mode};
    else beat = {c.t1, c.t0, c.rate, c.accel, rand48(), c.mode};
    while (idle_now()) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data = beat;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_beat(c);
    @(negedge clk);
    in_ch.valid = 1'b0;
    in_ch.data = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom});
  endtask

  task automatic push_sample(logic [47:0] t, logic [47:0] acc, logic [47:0] rat);
    iwi_cmd_t c;
    c.mode = MODE_PUSH;
    c.t0 = t;
    c.t1 = rand48();
    c.accel = acc;
    c.rate = rat;
    send_beat(c);
  endtask

  task automatic query_window(logic [47:0] s, logic [47:0] e);
    iwi_cmd_t c;
    c.mode = MODE_QUERY;
    c.t0 = s;
    c.t1 = e;
    c.accel = rand48();
    c.rate = rand48();
    send_beat(c);
  endtask

  // camera time that lands on imu time t under the current offset
  function logic [47:0] cam_for(longint t);
    longint c;
    c = t - longint'($signed(sb.cam_offset));
    if (c < 0) return '0;
    if (c > longint'({16'h0, T48_MAX})) return T48_MAX;
    return c[47:0];
  endfunction

  task automatic wait_drained();
    while (sb.window_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_offset(logic [31:0] v);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    sb.cam_offset = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = $urandom;
  endtask

  task automatic push_next();
    int r;
    r = $urandom_range(99);
    if (r < 4 && sb.fill > 0) begin
      push_sample(sb.newest_time() - $urandom_range(1, 100), rand48(), rand48());
      return;
    end
    if (r >= 12) next_time = next_time + $urandom_range(1, 5000);
    push_sample(next_time, rand48(), rand48());
  endtask

  task automatic query_random();
    longint ts, te;
    int r, i;
    r = $urandom_range(99);
    if (r < 8 || sb.fill == 0) begin
      query_window(rand48(), rand48());
      return;
    end
    i = $urandom_range(sb.fill - 1);
    ts = longint'(sb.time_ring[sb.slot(i)]) + $urandom_range(0, 6000) - 3000;
    if (r < 16) te = ts - $urandom_range(1, 3000);
    else if (r < 30) te = longint'(next_time) + 10000;
    else te = ts + $urandom_range(0, 60000);
    query_window(cam_for(ts), cam_for(te));
  endtask

  task automatic random_phase(int n, int hold_at);
    for (int k = 0; k < n; k++) begin
      no_idle = (k >= n / 2 && k < n / 2 + 25);
      if (k == hold_at) hold_req = 1'b1;
      if ($urandom_range(99) < 70) push_next();
      else query_random();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    idle_count = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty ring, extremes, out-of-order, equal time, bounds
    query_window(48'd100, 48'd200);
    push_sample(48'd1000, {16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000});
    query_window(48'd1000, 48'd1000);
    push_sample(48'd2000, {16'h8000, 16'h7FFF, 16'h8000}, {16'h7FFF, 16'h8000, 16'h7FFF});
    push_sample(48'd1500, 48'h1234_5678_9ABC, 48'h0);
    push_sample(48'd2000, 48'hFFFF_FFFF_FFFF, 48'h0001_0001_0001);
    push_sample(48'd3001, 48'h0, 48'hFFFF_0000_FFFF);
    query_window(48'd1000, 48'd3001);
    query_window(48'd1001, 48'd2999);
    query_window(48'd1500, 48'd2500);
    query_window(48'd2500, 48'd1500);
    query_window(48'd999, 48'd2000);
    query_window(48'd1200, 48'd3002);
    query_window(48'd0, T48_MAX);
    query_window(T48_MAX, 48'd0);
    query_window(48'd1999, 48'd2000);
    for (int k = 0; k < 6; k++) push_sample(48'd4000 + 48'(k * 7), rand48(), rand48());
    query_window(48'd1001, 48'd4034);

    next_time = 48'h3_0000_0000;
    write_offset(32'h0000_0000);
    random_phase(90, 40);
    wait_drained();
    write_offset(32'h7FFF_FFFF);
    random_phase(80, -1);
    write_offset(32'h8000_0000);
    random_phase(80, -1);
    write_offset($urandom);
    random_phase(80, -1);
    next_time = T48_MAX - 48'h40_0000;
    write_offset(32'h7FFF_FFFF);
    random_phase(60, -1);
    query_window(T48_MAX, T48_MAX);
    query_window(48'd0, T48_MAX);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.window_results_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
